// ===== hdl/firmware_config_item_port_unit_defines.svh =====
// Assertion macros shared by the checker files of the item port unit.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef FIRMWARE_CONFIG_ITEM_PORT_UNIT_DEFINES_SVH
`define FIRMWARE_CONFIG_ITEM_PORT_UNIT_DEFINES_SVH

// same-cycle implication
`define FCIP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FCIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/fcip_pkg.sv =====
// Shared constants of the item port unit: field widths, command, port and status codes.
// No dependencies.
package fcip_pkg;

  localparam int ITEM_SLOTS_DEF     = 32;
  localparam int MAX_ITEM_BYTES_DEF = 4096;
  localparam int STORE_BYTES_DEF    = 8192;

  localparam int KEY_W   = 16;
  localparam int SIZE_W  = 16;
  localparam int OFF_W   = 12;
  localparam int BYTE_W  = 8;
  localparam int ASZ_W   = 3;
  localparam int WVAL_W  = 32;
  localparam int RVAL_W  = 32;
  localparam int STAT_W  = 3;
  localparam int CMD_W   = 2;
  localparam int PK_W    = 2;

  localparam int IN_TDATA_W  = 88;
  localparam int IN_TUSER_W  = 5;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PORT = 2'd2;

  localparam logic [PK_W-1:0] PORT_SEL  = 2'd0;
  localparam logic [PK_W-1:0] PORT_DATA = 2'd1;

  localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
  localparam logic [STAT_W-1:0] STAT_TOO_LARGE  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_TABLE_FULL = 3'd2;
  localparam logic [STAT_W-1:0] STAT_DUP_KEY    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_STORE_FULL = 3'd4;

  localparam logic [ASZ_W-1:0] MAX_ACCESS = 3'd4;

endpackage

// ===== hdl/fcip_entry_table.sv =====
// Item table memory: key, length and base of each item, one write and one read port.
// Read data registered. Uses no package items.
module fcip_entry_table #(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5,
  parameter int DATA_W = 45
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/fcip_byte_store.sv =====
// Byte store memory shared by all items, one write and one read port.
// Read data registered. Uses no package items.
module fcip_byte_store #(
  parameter int DEPTH  = 8192,
  parameter int ADDR_W = 13
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/firmware_config_item_port_unit.sv =====
// Keyed item store behind a selector port and a data port. One item is worked at a time:
// in_tready is high only while the unit is idle, and a result waits in the output register.
// An add that is not rejected early scans the stored keys, one item-table entry read per
// cycle, and a duplicate add ends the scan at the hit; a selector write scans the same
// way. A load reads the entry of the newest item and may then write one byte. A data-port
// read of n bytes reads them one at a time, each byte one read of the byte store; it
// ends at once when nothing is selected. The finished result holds the unit for as long
// as the previous result still waits in the output register. There is no clearing pass
// after reset.
// Depends on fcip_pkg, fcip_entry_table and fcip_byte_store.
module firmware_config_item_port_unit
  import fcip_pkg::*;
#(
  parameter int ITEM_SLOTS     = ITEM_SLOTS_DEF,
  parameter int MAX_ITEM_BYTES = MAX_ITEM_BYTES_DEF,
  parameter int STORE_BYTES    = STORE_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // key[15:0], item_size[31:16], load_offset[43:32], load_byte[51:44],
  // access_size[54:52], write_value[86:55], zero[87]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd[1:0], port_kind[3:2], port_write[4]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // read_value[31:0], status[34:32], zero[39:35]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int IDX_W  = (ITEM_SLOTS > 1) ? $clog2(ITEM_SLOTS) : 1;
  localparam int CNT_W  = $clog2(ITEM_SLOTS + 1);
  localparam int LEN_W  = $clog2(MAX_ITEM_BYTES + 1);
  localparam int FREE_W = $clog2(STORE_BYTES + 1);
  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int ENT_W  = KEY_W + LEN_W + FREE_W;

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SCAN   = 8'b0000_0010,
    ST_LREAD  = 8'b0000_0100,
    ST_LCHK   = 8'b0000_1000,
    ST_RISSUE = 8'b0001_0000,
    ST_RCAP   = 8'b0010_0000,
    ST_DONE   = 8'b0100_0000,
    ST_SPARE  = 8'b1000_0000
  } state_t;

  // input fields
  logic [KEY_W-1:0]  in_key;
  logic [SIZE_W-1:0] in_size;
  logic [OFF_W-1:0]  in_off;
  logic [BYTE_W-1:0] in_lbyte;
  logic [ASZ_W-1:0]  in_asz;
  logic [WVAL_W-1:0] in_wval;
  logic [CMD_W-1:0]  in_cmd;
  logic [PK_W-1:0]   in_pk;
  logic              in_wr;

  assign in_key   = in_tdata[15:0];
  assign in_size  = in_tdata[31:16];
  assign in_off   = in_tdata[43:32];
  assign in_lbyte = in_tdata[51:44];
  assign in_asz   = in_tdata[54:52];
  assign in_wval  = in_tdata[86:55];
  assign in_cmd   = in_tuser[1:0];
  assign in_pk    = in_tuser[3:2];
  assign in_wr    = in_tuser[4];

  state_t            state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [BYTE_W-1:0] lbyte_r, lbyte_nxt;
  logic [ASZ_W-1:0]  nbytes_r, nbytes_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [FREE_W-1:0] free_r, free_nxt;
  logic              sel_vld_r, sel_vld_nxt;
  logic [IDX_W-1:0]  sel_idx_r, sel_idx_nxt;
  logic [LEN_W-1:0]  cursor_r, cursor_nxt;
  logic [CNT_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic [ASZ_W-1:0]  byte_b_r, byte_b_nxt;
  logic [RVAL_W-1:0] res_rv_r, res_rv_nxt;
  logic [STAT_W-1:0] res_st_r, res_st_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // memory ports
  logic              tbl_we;
  logic [IDX_W-1:0]  tbl_waddr, tbl_raddr;
  logic [ENT_W-1:0]  tbl_wdata, tbl_rdata;
  logic              bs_we;
  logic [ADDR_W-1:0] bs_waddr, bs_raddr;
  logic [7:0]        bs_rdata;

  logic [KEY_W-1:0]  ent_key;
  logic [LEN_W-1:0]  ent_len;
  logic [FREE_W-1:0] ent_base;
  logic [FREE_W-1:0] free_left;
  logic [CNT_W-1:0]  cnt_m1;
  logic [ADDR_W-1:0] rd_pos, ld_pos;
  logic [ASZ_W-1:0]  in_nbytes;
  logic              scan_issue, scan_hit, scan_miss;

  assign ent_key   = tbl_rdata[ENT_W-1 -: KEY_W];
  assign ent_len   = tbl_rdata[FREE_W +: LEN_W];
  assign ent_base  = tbl_rdata[FREE_W-1:0];
  assign free_left = FREE_W'(STORE_BYTES) - free_r;
  assign cnt_m1    = count_r - CNT_W'(1);
  assign rd_pos    = ADDR_W'(32'(ent_base) + 32'(cursor_r));
  assign ld_pos    = ADDR_W'(32'(ent_base) + 32'(off_r));
  assign in_nbytes = (in_asz > MAX_ACCESS) ? MAX_ACCESS : in_asz;

  assign scan_issue = (scan_idx_r < count_r);
  assign scan_hit   = cmp_vld_r && (ent_key == key_r);
  assign scan_miss  = !scan_hit && !cmp_vld_r && !scan_issue;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    key_nxt      = key_r;
    size_nxt     = size_r;
    off_nxt      = off_r;
    lbyte_nxt    = lbyte_r;
    nbytes_nxt   = nbytes_r;
    count_nxt    = count_r;
    free_nxt     = free_r;
    sel_vld_nxt  = sel_vld_r;
    sel_idx_nxt  = sel_idx_r;
    cursor_nxt   = cursor_r;
    scan_idx_nxt = scan_idx_r;
    cmp_vld_nxt  = cmp_vld_r;
    cmp_idx_nxt  = cmp_idx_r;
    byte_b_nxt   = byte_b_r;
    res_rv_nxt   = res_rv_r;
    res_st_nxt   = res_st_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_data_nxt = out_data_r;

    tbl_we    = 1'b0;
    tbl_waddr = count_r[IDX_W-1:0];
    tbl_wdata = {key_r, LEN_W'(size_r), free_r};
    tbl_raddr = sel_idx_r;
    bs_we     = 1'b0;
    bs_waddr  = ld_pos;
    bs_raddr  = rd_pos;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt      = in_cmd;
          size_nxt     = in_size;
          off_nxt      = in_off;
          lbyte_nxt    = in_lbyte;
          nbytes_nxt   = in_nbytes;
          res_rv_nxt   = '0;
          res_st_nxt   = STAT_OK;
          scan_idx_nxt = '0;
          cmp_vld_nxt  = 1'b0;
          byte_b_nxt   = '0;
          state_nxt    = ST_DONE;
          case (in_cmd)
            CMD_ADD: begin
              key_nxt = in_key;
              if (32'(in_size) > 32'(MAX_ITEM_BYTES)) begin
                res_st_nxt = STAT_TOO_LARGE;
              end else if (32'(count_r) >= 32'(ITEM_SLOTS)) begin
                res_st_nxt = STAT_TABLE_FULL;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            CMD_LOAD: begin
              if (count_r != '0) begin
                state_nxt = ST_LREAD;
              end
            end
            CMD_PORT: begin
              key_nxt = in_wval[KEY_W-1:0];
              if (in_pk == PORT_SEL && in_wr) begin
                state_nxt = ST_SCAN;
              end else if (in_pk == PORT_DATA && !in_wr && sel_vld_r &&
                           in_nbytes != '0) begin
                // table read port already points at the selected item
                state_nxt = ST_RISSUE;
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        tbl_raddr = scan_idx_r[IDX_W-1:0];
        if (scan_issue) begin
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
          cmp_vld_nxt  = 1'b1;
          cmp_idx_nxt  = scan_idx_r[IDX_W-1:0];
        end else begin
          cmp_vld_nxt = 1'b0;
        end
        if (scan_hit) begin
          state_nxt = ST_DONE;
          if (cmd_r == CMD_ADD) begin
            res_st_nxt = STAT_DUP_KEY;
          end else begin
            sel_vld_nxt = 1'b1;
            sel_idx_nxt = cmp_idx_r;
            cursor_nxt  = '0;
          end
        end else if (scan_miss) begin
          state_nxt = ST_DONE;
          if (cmd_r == CMD_ADD) begin
            if (32'(size_r) > 32'(free_left)) begin
              res_st_nxt = STAT_STORE_FULL;
            end else begin
              tbl_we    = 1'b1;
              count_nxt = count_r + CNT_W'(1);
              free_nxt  = free_r + FREE_W'(size_r);
            end
          end else begin
            sel_vld_nxt = 1'b0;
            sel_idx_nxt = '0;
            cursor_nxt  = '0;
          end
        end
      end

      ST_LREAD: begin
        tbl_raddr = cnt_m1[IDX_W-1:0];
        state_nxt = ST_LCHK;
      end

      ST_LCHK: begin
        tbl_raddr = cnt_m1[IDX_W-1:0];
        // drop loads at or past the end of the newest item
        if (32'(off_r) < 32'(ent_len)) begin
          bs_we = 1'b1;
        end
        state_nxt = ST_DONE;
      end

      ST_RISSUE: begin
        if (byte_b_r == nbytes_r || cursor_r >= ent_len) begin
          // remaining bytes read as zero, cursor holds
          state_nxt = ST_DONE;
        end else begin
          cursor_nxt = cursor_r + LEN_W'(1);
          state_nxt  = ST_RCAP;
        end
      end

      ST_RCAP: begin
        res_rv_nxt = res_rv_r | (RVAL_W'(bs_rdata) << {byte_b_r[1:0], 3'b000});
        byte_b_nxt = byte_b_r + ASZ_W'(1);
        state_nxt  = ST_RISSUE;
      end

      ST_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt  = 1'b1;
          out_data_nxt = {{(OUT_TDATA_W - STAT_W - RVAL_W){1'b0}}, res_st_r, res_rv_r};
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      free_r    <= '0;
      sel_vld_r <= 1'b0;
      sel_idx_r <= '0;
      cursor_r  <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      free_r    <= free_nxt;
      sel_vld_r <= sel_vld_nxt;
      sel_idx_r <= sel_idx_nxt;
      cursor_r  <= cursor_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    size_r     <= size_nxt;
    off_r      <= off_nxt;
    lbyte_r    <= lbyte_nxt;
    nbytes_r   <= nbytes_nxt;
    scan_idx_r <= scan_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    byte_b_r   <= byte_b_nxt;
    res_rv_r   <= res_rv_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
  end

  fcip_entry_table #(
    .DEPTH  (ITEM_SLOTS),
    .ADDR_W (IDX_W),
    .DATA_W (ENT_W)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  fcip_byte_store #(
    .DEPTH  (STORE_BYTES),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (bs_we),
    .waddr (bs_waddr),
    .wdata (lbyte_r),
    .raddr (bs_raddr),
    .rdata (bs_rdata)
  );

endmodule

// ===== hdl/fcip_checker.sv =====
// Port-level checks of the item port unit, bound to the top level.
// Depends on fcip_pkg and firmware_config_item_port_unit_defines.svh.
`include "firmware_config_item_port_unit_defines.svh"

module fcip_checker
  import fcip_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result item holds
  `FCIP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result item changed while stalled")

  // one item in flight: no second item right after an accept
  `FCIP_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready, "input taken while busy")

  // status code stays in its range
  `FCIP_ASSERT_NOW(a_status_range, out_tvalid, out_tdata[34:32] <= STAT_STORE_FULL, "status code out of range")

  // only an add reports status, and an add returns no read data
  `FCIP_ASSERT_NOW(a_status_no_data, out_tvalid && out_tdata[34:32] != STAT_OK, out_tdata[31:0] == '0, "read data with nonzero status")

endmodule

bind firmware_config_item_port_unit fcip_checker u_fcip_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
